// File: hw/rtl/bnlm_pkg.sv
// bnlm_pkg: types, table constants and codes for the same-phase raw denoise
// used by every module of the block; depends on nothing

package bnlm_pkg;

  typedef struct packed {
    logic        kind;
    logic [15:0] raw_sample;
    logic [27:0] noise_variance;
    logic        is_clipped;
  } in_t;

  typedef struct packed {
    logic [15:0] denoised_sample;
    logic        was_filtered;
  } out_t;

  typedef struct packed {
    logic        clip;
    logic [27:0] variance;
    logic [15:0] raw;
  } cell_t;

  localparam int WIN       = 13;
  localparam int LINES     = 12;
  localparam int GRID      = 7;
  localparam int GRID_N    = GRID * GRID;
  localparam int CENTER    = 24;
  localparam int MIN_WIDTH = 16;

  localparam int DVD_W = 48;
  localparam int DVS_W = 29;
  localparam int Q_W   = 16;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID   = 4'd1;

  typedef logic [16:0] exp_t;

  localparam exp_t EI_TAB [8] = '{
    17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162, 17'd60
  };
  localparam exp_t EF_TAB [8] = '{
    17'd65536, 17'd57835, 17'd51039, 17'd45042, 17'd39750, 17'd35079, 17'd30957, 17'd27319
  };

endpackage

// File: hw/rtl/bnlm_window.sv
// bnlm_window: twelve line rows in one column-wide memory plus the 13x13 window
// registers; exports the 7x7 same-phase grid; depends on bnlm_pkg

module bnlm_window #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]           rd_addr,
  input  logic                                   wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]           wr_addr,
  input  bnlm_pkg::cell_t                        cell_d,
  output bnlm_pkg::cell_t [bnlm_pkg::GRID_N-1:0] grid
);
  import bnlm_pkg::*;

  localparam int CB = $bits(cell_t);

  logic [LINES-1:0][CB-1:0] mem [MAX_WIDTH];
  logic [LINES-1:0][CB-1:0] rd_q;
  logic [LINES-1:0][CB-1:0] wr_row;
  cell_t                    column [WIN];
  cell_t                    win [WIN][WIN];

  always_comb begin
    for (int r = 0; r < LINES; r++) begin
      column[r] = cell_t'(rd_q[r]);
    end
    column[LINES] = cell_d;
    for (int r = 0; r < LINES; r++) begin
      wr_row[r] = column[r+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN - 1; c++) begin
          win[r][c] <= win[r][c+1];
        end
        win[r][WIN-1] <= column[r];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < GRID; i++) begin
      for (int j = 0; j < GRID; j++) begin
        grid[i*GRID+j] = win[2*i][2*j];
      end
    end
  end

endmodule

// File: hw/rtl/bnlm_div.sv
// bnlm_div: shared restoring divider, one quotient bit per cycle, 16-bit quotient
// the caller guarantees the quotient fits; depends on bnlm_pkg

module bnlm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bnlm_pkg::DVD_W-1:0]   dividend,
  input  logic [bnlm_pkg::DVS_W-1:0]   divisor,
  output logic [bnlm_pkg::Q_W-1:0]     quotient,
  output logic                         done
);
  import bnlm_pkg::*;

  logic [DVS_W-1:0]   rem;
  logic [DVS_W-1:0]   dvs;
  logic [Q_W-1:0]     lo;
  logic [$clog2(Q_W)-1:0] cnt;
  logic               busy;
  logic [DVS_W:0]     trial;
  logic               ge;

  assign trial    = {rem, lo[Q_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == $clog2(Q_W)'(Q_W - 1));
      if (start) begin
        rem  <= dividend[Q_W+DVS_W-1:Q_W];
        lo   <= dividend[Q_W-1:0];
        dvs  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
        lo  <= {lo[Q_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == $clog2(Q_W)'(Q_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// File: hw/rtl/bnlm_engine.sv
// bnlm_engine: sequencer for patch distances, weights and the weighted mean
// uses one shared multiplier and bnlm_div; depends on bnlm_pkg

module bnlm_engine (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [3:0]                             min_valid,
  input  bnlm_pkg::cell_t [bnlm_pkg::GRID_N-1:0] grid,
  output logic [15:0]                            result,
  output logic                                   done
);
  import bnlm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CAND, S_FETCH, S_TERM, S_MWAIT, S_CMP, S_TDIV, S_PNEXT,
    S_PDONE, S_MDIV, S_WGT, S_ACC, S_NEXT, S_FDIV, S_FWAIT
  } state_t;

  state_t state, ret;

  logic [2:0]  cy, cx;
  logic [1:0]  py, px;
  cell_t       ca, cb;
  logic [28:0] vs;
  logic [19:0] acc;
  logic [3:0]  n;
  logic [37:0] num;
  logic [21:0] den;
  logic [16:0] wreg;
  logic [16:0] mul_a, mul_b;
  logic [33:0] prod;

  logic             div_start, div_done, div_go;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic [Q_W-1:0]   div_q;

  logic [5:0]  ia, ib, ic;
  logic [28:0] vsum;
  logic [15:0] dabs;
  logic        tvalid;
  logic [15:0] xv;
  logic [16:0] wgt;

  function automatic logic [5:0] gidx(input logic [2:0] r, input logic [2:0] c);
    return 6'(r * GRID + c);
  endfunction

  assign ia     = gidx(3'(py) + 3'd2, 3'(px) + 3'd2);
  assign ib     = gidx(cy - 3'd1 + 3'(py), cx - 3'd1 + 3'(px));
  assign ic     = gidx(cy, cx);
  assign vsum   = {1'b0, ca.variance} + {1'b0, cb.variance};
  assign dabs   = (ca.raw > cb.raw) ? ca.raw - cb.raw : cb.raw - ca.raw;
  assign tvalid = !ca.clip && !cb.clip && (vsum != '0);
  assign xv     = div_q - 16'd256;
  assign wgt    = 17'((prod + 34'd32768) >> 16);
  assign div_go = (state == S_CMP && prod[31:0] < 32'(vs))
               || (state == S_PDONE && n != '0 && n >= min_valid)
               || (state == S_FDIV);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  bnlm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      div_start <= 1'b0;
    end else begin
      done      <= (state == S_FWAIT) && div_done;
      div_start <= div_go;
      case (state)
        S_IDLE: begin
          if (start) begin
            num   <= 38'({grid[CENTER].raw, 16'h0});
            den   <= 22'd65536;
            cy    <= 3'd1;
            cx    <= 3'd1;
            state <= S_CAND;
          end
        end
        S_CAND: begin
          if ((cy == 3'd3 && cx == 3'd3) || grid[ic].clip) begin
            state <= S_NEXT;
          end else begin
            acc   <= '0;
            n     <= '0;
            py    <= '0;
            px    <= '0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          ca    <= grid[ia];
          cb    <= grid[ib];
          state <= S_TERM;
        end
        S_TERM: begin
          if (tvalid) begin
            vs    <= vsum;
            mul_a <= 17'(dabs);
            mul_b <= 17'(dabs);
            ret   <= S_CMP;
            state <= S_MWAIT;
          end else begin
            state <= S_PNEXT;
          end
        end
        S_MWAIT: begin
          state <= ret;
        end
        S_CMP: begin
          if (prod[31:0] >= 32'(vs)) begin
            acc   <= acc + 20'd65535;
            n     <= n + 1'b1;
            state <= S_PNEXT;
          end else begin
            div_dvd <= {prod[31:0], 16'h0};
            div_dvs <= vs;
            state   <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (div_done) begin
            acc   <= acc + 20'(div_q);
            n     <= n + 1'b1;
            state <= S_PNEXT;
          end
        end
        S_PNEXT: begin
          if (px == 2'd2) begin
            px <= '0;
            if (py == 2'd2) begin
              state <= S_PDONE;
            end else begin
              py    <= py + 1'b1;
              state <= S_FETCH;
            end
          end else begin
            px    <= px + 1'b1;
            state <= S_FETCH;
          end
        end
        S_PDONE: begin
          if (n == '0 || n < min_valid) begin
            state <= S_NEXT;
          end else begin
            div_dvd <= DVD_W'(acc);
            div_dvs <= DVS_W'(n);
            state   <= S_MDIV;
          end
        end
        S_MDIV: begin
          if (div_done) begin
            if (div_q > 16'd256 && xv[15:10] == '0) begin
              mul_a <= EI_TAB[xv[9:7]];
              mul_b <= EF_TAB[xv[6:4]];
              ret   <= S_WGT;
              state <= S_MWAIT;
            end else if (div_q <= 16'd256) begin
              mul_a <= EI_TAB[0];
              mul_b <= EF_TAB[0];
              ret   <= S_WGT;
              state <= S_MWAIT;
            end else begin
              state <= S_NEXT;
            end
          end
        end
        S_WGT: begin
          wreg  <= wgt;
          mul_a <= wgt;
          mul_b <= 17'(grid[ic].raw);
          ret   <= S_ACC;
          state <= S_MWAIT;
        end
        S_ACC: begin
          num   <= num + 38'(prod[32:0]);
          den   <= den + 22'(wreg);
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (cx == 3'd5) begin
            cx <= 3'd1;
            if (cy == 3'd5) begin
              state <= S_FDIV;
            end else begin
              cy    <= cy + 1'b1;
              state <= S_CAND;
            end
          end else begin
            cx    <= cx + 1'b1;
            state <= S_CAND;
          end
        end
        S_FDIV: begin
          div_dvd <= DVD_W'({num, 1'b0}) + DVD_W'(den);
          div_dvs <= DVS_W'({den, 1'b0});
          state   <= S_FWAIT;
        end
        S_FWAIT: begin
          if (div_done) begin
            result <= div_q;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/bayer_same_phase_nlm_denoise.sv
// bayer_same_phase_nlm_denoise: top level with counters, config and handshakes
// depends on bnlm_pkg, bnlm_window, bnlm_engine
//
// raw bayer pixels enter on in_valid/in_ready in raster order, flush items after
// frame end drain the tail; results leave on out_valid/out_ready in order.
// the result for a target appears 6*w+6 transactions after it entered.
// configuration writes on cfg_valid/cfg_ready (always ready) while idle:
// index 0 frame width, index 1 minimum valid patch terms.
// a pass-through item goes through line memory read, window shift, decide and
// output load. a filtered target runs the shared engine over 24 candidates of
// 9 pair terms each, with at most one divider round trip per term.
// an item is taken while the previous result still waits in the output
// register; a stalled receiver holds the block once the next result is ready.
// reset clears counters and handshakes and restores the register defaults;
// line memory and window contents stay undefined until written.

module bayer_same_phase_nlm_denoise #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  bnlm_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output bnlm_pkg::out_t                       out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bnlm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [12:0]                          cfg_data
);
  import bnlm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int LW = CW + 3;

  typedef enum logic [2:0] {T_IDLE, T_SHIFT, T_EVAL, T_RUN, T_OUT} state_t;

  state_t state;

  logic [12:0]   frame_width;
  logic [3:0]    min_valid_terms;
  logic [CW-1:0] col;
  logic [3:0]    row;
  logic [LW-1:0] flush;

  logic [CW-1:0] w_eff;
  logic [LW-1:0] lag;
  logic          accept, fl_clear, drop, reached, inter;
  logic [CW-1:0] col_b, col_e, col_inc;
  logic [3:0]    row_b;
  logic [LW-1:0] flush_b;
  cell_t         cell_in;

  logic [AW-1:0] addr_q;
  cell_t         cell_q;
  logic          reached_q, inter_q;
  out_t          res_pend;
  logic          run_go, out_load;

  cell_t [GRID_N-1:0] grid;
  logic               eng_start, eng_done;
  logic [15:0]        eng_result;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == T_IDLE);
  assign accept    = in_valid && in_ready;
  assign run_go    = reached_q && inter_q && !grid[CENTER].clip
                     && grid[CENTER].variance != '0;
  assign out_load  = (state == T_OUT) && (!out_valid || out_ready);

  always_comb begin
    if (frame_width < 13'(MIN_WIDTH)) begin
      w_eff = CW'(MIN_WIDTH);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(frame_width);
    end
    lag      = LW'(6 * 32'(w_eff) + 6);
    fl_clear = !in_data.kind && (flush != '0);
    col_b    = fl_clear ? '0 : col;
    row_b    = fl_clear ? '0 : row;
    flush_b  = fl_clear ? '0 : flush;
    drop     = in_data.kind && (flush >= lag);
    col_e    = (col_b >= w_eff) ? '0 : col_b;
    col_inc  = col_e + 1'b1;
    reached  = (row_b > 4'd6) || (row_b == 4'd6 && col_e >= CW'(6));
    inter    = !in_data.kind && (row_b >= 4'd12) && (col_e >= CW'(12));
    if (in_data.kind) begin
      cell_in = '0;
    end else begin
      cell_in = '{clip: in_data.is_clipped, variance: in_data.noise_variance,
                  raw: in_data.raw_sample};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= 13'd4096;
      min_valid_terms <= 4'd7;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH: frame_width     <= cfg_data;
        REG_MIN_VALID:   min_valid_terms <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      col       <= '0;
      row       <= '0;
      flush     <= '0;
      out_valid <= 1'b0;
      eng_start <= 1'b0;
    end else begin
      eng_start <= (state == T_EVAL) && run_go;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (accept && !drop) begin
            flush     <= in_data.kind ? flush + 1'b1 : flush_b;
            addr_q    <= col_e[AW-1:0];
            cell_q    <= cell_in;
            reached_q <= reached;
            inter_q   <= inter;
            if (col_inc >= w_eff) begin
              col <= '0;
              row <= (row_b < 4'd13) ? row_b + 1'b1 : row_b;
            end else begin
              col <= col_inc;
              row <= row_b;
            end
            state <= T_SHIFT;
          end
        end
        T_SHIFT: begin
          state <= T_EVAL;
        end
        T_EVAL: begin
          if (!reached_q) begin
            state <= T_IDLE;
          end else if (run_go) begin
            state <= T_RUN;
          end else begin
            res_pend <= '{denoised_sample: grid[CENTER].raw, was_filtered: 1'b0};
            state    <= T_OUT;
          end
        end
        T_RUN: begin
          if (eng_done) begin
            res_pend <= '{denoised_sample: eng_result, was_filtered: 1'b1};
            state    <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_load) begin
            out_data <= res_pend;
            state    <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  bnlm_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_e[AW-1:0]),
    .wr_en   (state == T_SHIFT),
    .wr_addr (addr_q),
    .cell_d  (cell_q),
    .grid    (grid)
  );

  bnlm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (eng_start),
    .min_valid (min_valid_terms),
    .grid      (grid),
    .result    (eng_result),
    .done      (eng_done)
  );

endmodule

// File: hw/rtl/bnlm_checker.sv
// bnlm_checker: port-level assertions for the denoise top level, bound to it
// depends on bnlm_pkg

module bnlm_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input bnlm_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while input side idle");

  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result too soon after input transaction");

endmodule

bind bayer_same_phase_nlm_denoise bnlm_checker u_checker (.*);
